/* rtl/core/bole_pkg.sv */
// Package for the bounded ordered list engine.
// Holds sizes, command and status codes, cell control and beat structs.
// No dependencies.
package bole_pkg;

  localparam int DEPTH   = 16;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int VALUE_W = 32;
  localparam int ENTRY_W = 5;

  typedef enum logic [2:0] {
    MODE_APPEND    = 3'd0,
    MODE_POP_FRONT = 3'd1,
    MODE_POP_BACK  = 3'd2,
    MODE_DELETE    = 3'd3,
    MODE_TRAVERSE  = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_EMPTY    = 2'd1,
    STAT_NOTFOUND = 2'd2,
    STAT_FULL     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_TRAV
  } state_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_APPEND,
    CELL_SHIFT,
    CELL_DELETE,
    CELL_ROTATE
  } cell_op_t;

  typedef struct packed {
    logic [2:0]                mode;
    logic signed [VALUE_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    status_t                   status;
    logic signed [VALUE_W-1:0] item_value;
    logic [ENTRY_W-1:0]        entry_count;
    logic                      last;
  } result_t;

  typedef struct packed {
    cell_op_t                  op;
    logic [CNT_W-1:0]          count;
    logic signed [VALUE_W-1:0] value;
  } cell_ctl_t;

endpackage

/* rtl/core/bole_cell.sv */
// One list position of the cell chain: holds one entry and its neighbor handoff.
// Depends on bole_pkg.
module bole_cell
  import bole_pkg::*;
(
  input  logic                      clk,
  input  logic [IDX_W-1:0]          idx,
  input  cell_ctl_t                 ctl,
  input  logic signed [VALUE_W-1:0] right_data,
  input  logic signed [VALUE_W-1:0] head_data,
  input  logic                      hit_in,
  input  logic signed [VALUE_W-1:0] tail_in,
  output logic                      hit_out,
  output logic signed [VALUE_W-1:0] tail_out,
  output logic signed [VALUE_W-1:0] data
);

  logic [CNT_W-1:0]          idx_ext;
  logic                      valid;
  logic                      is_tail;
  logic                      match;
  logic signed [VALUE_W-1:0] data_next;

  assign idx_ext  = CNT_W'(idx);
  assign valid    = idx_ext < ctl.count;
  assign is_tail  = (idx_ext + CNT_W'(1)) == ctl.count;
  assign match    = valid && (data == ctl.value);
  assign hit_out  = hit_in | match;
  assign tail_out = tail_in | (is_tail ? data : '0);

  always_comb begin
    data_next = data;
    unique case (ctl.op)
      CELL_HOLD:   data_next = data;
      CELL_APPEND: if (idx_ext == ctl.count) data_next = ctl.value;
      CELL_SHIFT:  data_next = right_data;
      CELL_DELETE: if (hit_out) data_next = right_data;
      CELL_ROTATE: data_next = is_tail ? head_data : right_data;
      default:     data_next = data;
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

/* rtl/core/bounded_ordered_list_engine_unit.sv */
// Top level of the bounded ordered list engine: command FSM over a chain of cells.
// Depends on bole_pkg and bole_cell.
//
// A command is taken when start is high and busy is low. Each single-result
// command shows its result beat in the cycle after the execute cycle, and the
// next command can be taken in the cycle its result is on the ports. Traverse
// of n entries gives n beats, one per cycle, as the cell chain rotates once
// around the list. Delete-value searches all cells in its execute cycle. The
// receiver cannot stall: each beat is valid for exactly the one cycle that
// strobe is high.
module bounded_ordered_list_engine_unit
  import bole_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  cmd_t    cmd,
  output logic    busy,
  output logic    strobe,
  output result_t result
);

  state_t                    state;
  state_t                    state_next;
  cmd_t                      cmd_q;
  logic [CNT_W-1:0]          count;
  logic [CNT_W-1:0]          count_next;
  logic [CNT_W-1:0]          trav_left;
  logic [CNT_W-1:0]          trav_left_next;
  logic                      strobe_next;
  result_t                   result_next;
  cell_ctl_t                 ctl;

  logic signed [VALUE_W-1:0] data  [DEPTH];
  logic signed [VALUE_W-1:0] right [DEPTH];
  logic                      hit   [DEPTH+1];
  logic signed [VALUE_W-1:0] tail  [DEPTH+1];

  logic                      accept;
  logic                      empty;
  logic                      full;

  assign accept  = start && !busy;
  assign busy    = state != ST_IDLE;
  assign empty   = count == '0;
  assign full    = count == CNT_W'(DEPTH);
  assign hit[0]  = 1'b0;
  assign tail[0] = '0;

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      if (g < DEPTH - 1) begin : g_mid
        assign right[g] = data[g+1];
      end else begin : g_end
        assign right[g] = data[g];
      end
      bole_cell u_cell (
        .clk        (clk),
        .idx        (IDX_W'(g)),
        .ctl        (ctl),
        .right_data (right[g]),
        .head_data  (data[0]),
        .hit_in     (hit[g]),
        .tail_in    (tail[g]),
        .hit_out    (hit[g+1]),
        .tail_out   (tail[g+1]),
        .data       (data[g])
      );
    end
  endgenerate

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (accept) state_next = ST_EXEC;
      ST_EXEC: begin
        if (mode_t'(cmd_q.mode) == MODE_TRAVERSE && count > CNT_W'(1)) begin
          state_next = ST_TRAV;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_TRAV: if (trav_left == CNT_W'(1)) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl.op         = CELL_HOLD;
    ctl.count      = count;
    ctl.value      = cmd_q.value;
    count_next     = count;
    trav_left_next = trav_left;
    strobe_next    = 1'b0;
    result_next.status     = STAT_OK;
    result_next.item_value = '0;
    result_next.last       = 1'b1;
    unique case (state)
      ST_IDLE: ;
      ST_EXEC: begin
        strobe_next = 1'b1;
        unique case (mode_t'(cmd_q.mode))
          MODE_APPEND: begin
            if (full) begin
              result_next.status = STAT_FULL;
            end else begin
              ctl.op     = CELL_APPEND;
              count_next = count + CNT_W'(1);
            end
          end
          MODE_POP_FRONT: begin
            if (empty) begin
              result_next.status = STAT_EMPTY;
            end else begin
              ctl.op                 = CELL_SHIFT;
              result_next.item_value = data[0];
              count_next             = count - CNT_W'(1);
            end
          end
          MODE_POP_BACK: begin
            if (empty) begin
              result_next.status = STAT_EMPTY;
            end else begin
              result_next.item_value = tail[DEPTH];
              count_next             = count - CNT_W'(1);
            end
          end
          MODE_DELETE: begin
            if (empty) begin
              result_next.status = STAT_EMPTY;
            end else if (hit[DEPTH]) begin
              ctl.op                 = CELL_DELETE;
              result_next.item_value = cmd_q.value;
              count_next             = count - CNT_W'(1);
            end else begin
              result_next.status = STAT_NOTFOUND;
            end
          end
          MODE_TRAVERSE: begin
            if (empty) begin
              result_next.status = STAT_EMPTY;
            end else begin
              ctl.op                 = CELL_ROTATE;
              result_next.item_value = data[0];
              result_next.last       = count == CNT_W'(1);
              trav_left_next         = count - CNT_W'(1);
            end
          end
          default: ;
        endcase
      end
      ST_TRAV: begin
        strobe_next            = 1'b1;
        ctl.op                 = CELL_ROTATE;
        result_next.item_value = data[0];
        result_next.last       = trav_left == CNT_W'(1);
        trav_left_next         = trav_left - CNT_W'(1);
      end
      default: ;
    endcase
    result_next.entry_count = ENTRY_W'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      trav_left <= '0;
      strobe    <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      trav_left <= trav_left_next;
      strobe    <= strobe_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) cmd_q <= cmd;
    result <= result_next;
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("busy not raised after command beat");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("entry count beyond depth");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (strobe && result.status != STAT_OK) |-> result.item_value == '0)
    else $error("error beat carries nonzero value");

  a_last_gap: assert property (@(posedge clk) disable iff (rst)
    (strobe && result.last) |=> !strobe)
    else $error("beat directly after last beat");

endmodule

/* verif/list_checker.sv */
// Checker for the bounded ordered list engine: watches command and result beats,
// keeps its own copy of the list, predicts every result beat and compares it.
// Depends on bole_pkg.
module list_checker
  import bole_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  logic    busy,
  input  cmd_t    cmd,
  input  logic    strobe,
  input  result_t result,
  output int      mismatches,
  output int      outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  logic signed [VALUE_W-1:0] shadow_list [DEPTH];
  int unsigned               shadow_count;
  result_t                   expected_beats [$];
  int                        err_count;

  function automatic result_t make_beat(status_t st, logic signed [VALUE_W-1:0] v,
                                        logic is_last);
    result_t b;
    b.status      = st;
    b.item_value  = v;
    b.entry_count = ENTRY_W'(shadow_count);
    b.last        = is_last;
    return b;
  endfunction

  task automatic apply_list_cmd(input cmd_t c);
    int                        hit;
    logic signed [VALUE_W-1:0] taken;
    hit = -1;
    case (c.mode)
      MODE_APPEND: begin
        if (shadow_count >= DEPTH) begin
          expected_beats.push_back(make_beat(STAT_FULL, '0, 1'b1));
        end else begin
          shadow_list[shadow_count] = c.value;
          shadow_count++;
          expected_beats.push_back(make_beat(STAT_OK, '0, 1'b1));
        end
      end
      MODE_POP_FRONT: begin
        if (shadow_count == 0) begin
          expected_beats.push_back(make_beat(STAT_EMPTY, '0, 1'b1));
        end else begin
          taken = shadow_list[0];
          for (int i = 0; i + 1 < shadow_count; i++) shadow_list[i] = shadow_list[i+1];
          shadow_count--;
          expected_beats.push_back(make_beat(STAT_OK, taken, 1'b1));
        end
      end
      MODE_POP_BACK: begin
        if (shadow_count == 0) begin
          expected_beats.push_back(make_beat(STAT_EMPTY, '0, 1'b1));
        end else begin
          shadow_count--;
          expected_beats.push_back(make_beat(STAT_OK, shadow_list[shadow_count], 1'b1));
        end
      end
      MODE_DELETE: begin
        if (shadow_count == 0) begin
          expected_beats.push_back(make_beat(STAT_EMPTY, '0, 1'b1));
        end else begin
          for (int i = 0; i < shadow_count; i++) begin
            if (hit < 0 && shadow_list[i] == c.value) hit = i;
          end
          if (hit < 0) begin
            expected_beats.push_back(make_beat(STAT_NOTFOUND, '0, 1'b1));
          end else begin
            for (int i = hit; i + 1 < shadow_count; i++) shadow_list[i] = shadow_list[i+1];
            shadow_count--;
            expected_beats.push_back(make_beat(STAT_OK, c.value, 1'b1));
          end
        end
      end
      MODE_TRAVERSE: begin
        if (shadow_count == 0) begin
          expected_beats.push_back(make_beat(STAT_EMPTY, '0, 1'b1));
        end else begin
          for (int i = 0; i < shadow_count; i++) begin
            expected_beats.push_back(make_beat(STAT_OK, shadow_list[i],
                                               i + 1 == shadow_count));
          end
        end
      end
      default: begin
        expected_beats.push_back(make_beat(STAT_OK, '0, 1'b1));
      end
    endcase
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      shadow_count = 0;
      expected_beats.delete();
    end else begin
      if (strobe) begin
        if (expected_beats.size() == 0) begin
          $error("result beat with nothing expected: status %0d item_value %0d",
                 result.status, result.item_value);
          err_count++;
        end else begin
          want = expected_beats.pop_front();
          if (result.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, result.status);
            err_count++;
          end
          if (result.item_value !== want.item_value) begin
            $error("item_value: expected %0d, got %0d", want.item_value, result.item_value);
            err_count++;
          end
          if (result.entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, got %0d", want.entry_count,
                   result.entry_count);
            err_count++;
          end
          if (result.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, result.last);
            err_count++;
          end
        end
      end
      if (start && !busy) apply_list_cmd(cmd);
    end
    mismatches  <= err_count;
    outstanding <= expected_beats.size();
  end

endmodule

/* verif/testbench.sv */
// Top of the list engine testbench: clock, reset, command stimulus and verdict.
// Depends on bole_pkg, bounded_ordered_list_engine_unit and list_checker.
module testbench
  import bole_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_CMDS = 450;

  logic    clk   = 1'b0;
  logic    rst   = 1'b1;
  logic    start = 1'b0;
  cmd_t    cmd   = '0;
  logic    busy;
  logic    strobe;
  result_t result;
  int      mismatches;
  int      outstanding;
  int      cycles = 0;
  logic signed [VALUE_W-1:0] value_pool [8];

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  bounded_ordered_list_engine_unit u_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .cmd    (cmd),
    .busy   (busy),
    .strobe (strobe),
    .result (result)
  );

  list_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .cmd         (cmd),
    .strobe      (strobe),
    .result      (result),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send_cmd(input logic [2:0] m, input logic signed [VALUE_W-1:0] v,
                          input bit idle_ok);
    while (idle_ok && $urandom_range(99) < 33) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start      <= 1'b1;
    cmd.mode   <= m;
    cmd.value  <= v;
    do @(posedge clk); while (busy);
  endtask

  function automatic logic signed [VALUE_W-1:0] pick_value();
    int r;
    r = $urandom_range(99);
    if (r < 45) return value_pool[$urandom_range(7)];
    if (r < 50) return {1'b1, {(VALUE_W-1){1'b0}}};
    if (r < 55) return {1'b0, {(VALUE_W-1){1'b1}}};
    if (r < 58) return '0;
    if (r < 61) return '1;
    return VALUE_W'($urandom());
  endfunction

  function automatic logic [2:0] pick_mode(int phase_kind);
    int r;
    int w_app, w_pf, w_pb, w_del;
    r = $urandom_range(99);
    case (phase_kind)
      0:       begin w_app = 65; w_pf = 7;  w_pb = 7;  w_del = 7;  end
      1:       begin w_app = 20; w_pf = 20; w_pb = 20; w_del = 25; end
      default: begin w_app = 40; w_pf = 12; w_pb = 12; w_del = 20; end
    endcase
    if (r < w_app) return MODE_APPEND;
    r -= w_app;
    if (r < w_pf) return MODE_POP_FRONT;
    r -= w_pf;
    if (r < w_pb) return MODE_POP_BACK;
    r -= w_pb;
    if (r < w_del) return MODE_DELETE;
    r -= w_del;
    if (r < 10) return MODE_TRAVERSE;
    return MODE_TRAVERSE + 3'($urandom_range(3, 1));
  endfunction

  initial begin
    int sent;
    int phase_len;
    int phase_kind;
    bit idle_ok;
    logic signed [VALUE_W-1:0] v_min;
    logic signed [VALUE_W-1:0] v_max;
    v_min = {1'b1, {(VALUE_W-1){1'b0}}};
    v_max = {1'b0, {(VALUE_W-1){1'b1}}};
    value_pool[0] = v_min;
    value_pool[1] = v_max;
    for (int i = 2; i < 8; i++) value_pool[i] = VALUE_W'($urandom());

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // empty list, unused modes
    send_cmd(MODE_TRAVERSE, VALUE_W'($urandom()), 1'b1);
    send_cmd(MODE_POP_FRONT, '0, 1'b1);
    send_cmd(MODE_POP_BACK, '1, 1'b1);
    send_cmd(MODE_DELETE, v_max, 1'b1);
    send_cmd(MODE_TRAVERSE + 3'd1, v_min, 1'b1);
    send_cmd(MODE_TRAVERSE + 3'd2, '1, 1'b1);
    send_cmd(MODE_TRAVERSE + 3'd3, '0, 1'b1);
    // extremes and a duplicate
    send_cmd(MODE_APPEND, v_min, 1'b1);
    send_cmd(MODE_APPEND, v_max, 1'b1);
    send_cmd(MODE_APPEND, '0, 1'b1);
    send_cmd(MODE_APPEND, '1, 1'b1);
    send_cmd(MODE_APPEND, v_min, 1'b1);
    send_cmd(MODE_TRAVERSE, '1, 1'b1);
    send_cmd(MODE_DELETE, v_min, 1'b1);
    send_cmd(MODE_DELETE, 32'sd12345, 1'b1);
    send_cmd(MODE_TRAVERSE, '0, 1'b1);
    send_cmd(MODE_POP_FRONT, '0, 1'b1);
    send_cmd(MODE_POP_BACK, '0, 1'b1);
    send_cmd(MODE_TRAVERSE, '0, 1'b1);

    sent = 0;
    while (sent < RANDOM_CMDS) begin
      phase_len  = $urandom_range(60, 30);
      phase_kind = $urandom_range(2);
      if ($urandom_range(3) == 0) value_pool[$urandom_range(2, 7)] = VALUE_W'($urandom());
      for (int k = 0; k < phase_len && sent < RANDOM_CMDS; k++) begin
        idle_ok = !(sent >= 150 && sent < 230);
        send_cmd(pick_mode(phase_kind), pick_value(), idle_ok);
        sent++;
      end
    end
    start <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
